[rtl/jsud_pkg.sv]
`timescale 1ns / 1ps
package jsud_pkg;

	// Result kinds.
	localparam logic [1:0] KIND_DATA  = 2'd0;
	localparam logic [1:0] KIND_END   = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	// Error codes.
	localparam logic [2:0] ERR_NONE       = 3'd0;
	localparam logic [2:0] ERR_NUL_BYTE   = 3'd1;
	localparam logic [2:0] ERR_BAD_ESCAPE = 3'd2;
	localparam logic [2:0] ERR_BAD_HEX    = 3'd3;
	localparam logic [2:0] ERR_NUL_CODE   = 3'd4;
	localparam logic [2:0] ERR_LONE_LOW   = 3'd5;
	localparam logic [2:0] ERR_NO_LOW     = 3'd6;

	// One queue entry holds every result caused by one input byte.
	// last_idx is the index of the final result; bytes[0] goes out first.
	typedef struct packed {
		logic [1:0]      kind;
		logic [2:0]      err;
		logic [1:0]      last_idx;
		logic [3:0][7:0] bytes;
	} burst_t;

endpackage

[rtl/json_string_unescape_decoder.sv]
`timescale 1ns / 1ps
// JSON string body decoder.
// The source channel (src_valid, src_stall, in_byte) carries the string body one
// byte per request, starting after the opening quote. The result channel
// (res_valid, res_stall, kind, data_byte, error_code, last) gives decoded bytes,
// an end marker on the closing quote, or an error; last flags the final result
// caused by one input byte. Escape prefixes and partial \u sequences give none.
// A front scanner classifies one byte per cycle while the queue has room and
// writes all of its results (up to four) as one entry into a QUEUE_DEPTH-entry
// queue; the back end drains one result per cycle into an output register.
// The first result of a byte is written into the queue entry and then into the
// output register. Throughput: one byte per cycle while the queue has room; the
// result side moves one result per cycle unless res_stall holds it, so a byte
// yielding n results holds the back end for all n; the queue takes up the slack.
// src_stall is high only while the queue is full. A stalled result holds its
// value. Reset clears the scanner to normal text mode and empties the queue.
module json_string_unescape_decoder
	import jsud_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       src_valid,
	output logic       src_stall,
	input  logic [7:0] in_byte,
	output logic       res_valid,
	input  logic       res_stall,
	output logic [1:0] kind,
	output logic [7:0] data_byte,
	output logic [2:0] error_code,
	output logic       last
);

	logic   full;
	logic   push;
	burst_t push_data;
	logic   pop;
	logic   head_valid;
	burst_t head;

	assign src_stall = full;

	jsud_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (src_valid && !full),
		.in_byte   (in_byte),
		.push      (push),
		.push_data (push_data)
	);

	jsud_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	jsud_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.kind       (kind),
		.data_byte  (data_byte),
		.error_code (error_code),
		.last       (last)
	);

endmodule

[rtl/jsud_front.sv]
`timescale 1ns / 1ps
module jsud_front
	import jsud_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         take,
	input  logic [7:0]   in_byte,
	output logic         push,
	output burst_t       push_data
);

	typedef enum logic [4:0] {
		MODE_TEXT     = 5'b00001,
		MODE_ESC      = 5'b00010,
		MODE_HEX      = 5'b00100,
		MODE_WANT_BSL = 5'b01000,
		MODE_WANT_U   = 5'b10000
	} mode_t;

	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSL   = 8'h5c;
	localparam logic [7:0] CH_SLASH = 8'h2f;
	localparam logic [7:0] CH_B     = 8'h62;
	localparam logic [7:0] CH_F     = 8'h66;
	localparam logic [7:0] CH_N     = 8'h6e;
	localparam logic [7:0] CH_R     = 8'h72;
	localparam logic [7:0] CH_T     = 8'h74;
	localparam logic [7:0] CH_U     = 8'h75;
	localparam logic [7:0] CH_NUL   = 8'h00;

	mode_t       mode_q, mode_d;
	logic [1:0]  hex_cnt_q, hex_cnt_d;
	logic [15:0] accum_q, accum_d;
	logic        high_pend_q, high_pend_d;
	logic [9:0]  high_bits_q, high_bits_d;

	logic        hex_ok;
	logic [3:0]  hex_digit;
	logic [15:0] acc_new;
	logic [20:0] cp;
	logic        gen;
	burst_t      ent;

	always_comb begin
		hex_ok    = 1'b0;
		hex_digit = in_byte[3:0];
		if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
			hex_ok = 1'b1;
		end else if ((in_byte >= 8'h61 && in_byte <= 8'h66) ||
				(in_byte >= 8'h41 && in_byte <= 8'h46)) begin
			hex_ok    = 1'b1;
			hex_digit = in_byte[3:0] + 4'd9;
		end
	end

	assign acc_new = {accum_q[11:0], hex_digit};
	// Supplementary code point from the pending high half and a low half.
	assign cp = 21'h10000 + {1'b0, high_bits_q, acc_new[9:0]};

	always_comb begin
		mode_d      = mode_q;
		hex_cnt_d   = hex_cnt_q;
		accum_d     = accum_q;
		high_pend_d = high_pend_q;
		high_bits_d = high_bits_q;
		gen          = 1'b0;
		ent.kind     = KIND_DATA;
		ent.err      = ERR_NONE;
		ent.last_idx = 2'd0;
		ent.bytes    = '0;

		unique case (mode_q)
			MODE_ESC: begin
				mode_d = MODE_TEXT;
				gen    = 1'b1;
				case (in_byte)
					CH_QUOTE, CH_BSL, CH_SLASH: ent.bytes[0] = in_byte;
					CH_B: ent.bytes[0] = 8'h08;
					CH_F: ent.bytes[0] = 8'h0c;
					CH_N: ent.bytes[0] = 8'h0a;
					CH_R: ent.bytes[0] = 8'h0d;
					CH_T: ent.bytes[0] = 8'h09;
					CH_U: begin
						gen       = 1'b0;
						mode_d    = MODE_HEX;
						hex_cnt_d = 2'd0;
						accum_d   = 16'd0;
					end
					default: begin
						ent.kind = KIND_ERROR;
						ent.err  = ERR_BAD_ESCAPE;
					end
				endcase
			end
			MODE_HEX: begin
				if (!hex_ok) begin
					gen      = 1'b1;
					ent.kind = KIND_ERROR;
					ent.err  = ERR_BAD_HEX;
				end else if (hex_cnt_q != 2'd3) begin
					accum_d   = acc_new;
					hex_cnt_d = hex_cnt_q + 2'd1;
				end else begin
					accum_d   = 16'd0;
					hex_cnt_d = 2'd0;
					mode_d    = MODE_TEXT;
					gen       = 1'b1;
					if (high_pend_q) begin
						if (acc_new < 16'hdc00 || acc_new > 16'hdfff) begin
							ent.kind = KIND_ERROR;
							ent.err  = ERR_NO_LOW;
						end else begin
							ent.last_idx = 2'd3;
							ent.bytes[0] = 8'hf0 | {5'd0, cp[20:18]};
							ent.bytes[1] = 8'h80 | {2'd0, cp[17:12]};
							ent.bytes[2] = 8'h80 | {2'd0, cp[11:6]};
							ent.bytes[3] = 8'h80 | {2'd0, cp[5:0]};
							high_pend_d  = 1'b0;
							high_bits_d  = 10'd0;
						end
					end else if (acc_new == 16'd0) begin
						ent.kind = KIND_ERROR;
						ent.err  = ERR_NUL_CODE;
					end else if (acc_new < 16'h0080) begin
						ent.bytes[0] = acc_new[7:0];
					end else if (acc_new < 16'h0800) begin
						ent.last_idx = 2'd1;
						ent.bytes[0] = 8'hc0 | {3'd0, acc_new[10:6]};
						ent.bytes[1] = 8'h80 | {2'd0, acc_new[5:0]};
					end else if (acc_new >= 16'hd800 && acc_new <= 16'hdbff) begin
						// High half: wait for the low half, nothing goes out yet.
						gen         = 1'b0;
						high_pend_d = 1'b1;
						high_bits_d = acc_new[9:0];
						mode_d      = MODE_WANT_BSL;
					end else if (acc_new >= 16'hdc00 && acc_new <= 16'hdfff) begin
						ent.kind = KIND_ERROR;
						ent.err  = ERR_LONE_LOW;
					end else begin
						ent.last_idx = 2'd2;
						ent.bytes[0] = 8'he0 | {4'd0, acc_new[15:12]};
						ent.bytes[1] = 8'h80 | {2'd0, acc_new[11:6]};
						ent.bytes[2] = 8'h80 | {2'd0, acc_new[5:0]};
					end
				end
			end
			MODE_WANT_BSL: begin
				if (in_byte != CH_BSL) begin
					gen      = 1'b1;
					ent.kind = KIND_ERROR;
					ent.err  = ERR_NO_LOW;
				end else begin
					mode_d = MODE_WANT_U;
				end
			end
			MODE_WANT_U: begin
				if (in_byte != CH_U) begin
					gen      = 1'b1;
					ent.kind = KIND_ERROR;
					ent.err  = ERR_NO_LOW;
				end else begin
					mode_d    = MODE_HEX;
					hex_cnt_d = 2'd0;
					accum_d   = 16'd0;
				end
			end
			default: begin
				// Normal text; unused codes behave the same way.
				mode_d = MODE_TEXT;
				if (in_byte == CH_QUOTE) begin
					gen      = 1'b1;
					ent.kind = KIND_END;
				end else if (in_byte == CH_BSL) begin
					mode_d = MODE_ESC;
				end else if (in_byte == CH_NUL) begin
					gen      = 1'b1;
					ent.kind = KIND_ERROR;
					ent.err  = ERR_NUL_BYTE;
				end else begin
					gen          = 1'b1;
					ent.bytes[0] = in_byte;
				end
			end
		endcase

		// An end or an error returns the scanner to idle.
		if (gen && ent.kind != KIND_DATA) begin
			mode_d      = MODE_TEXT;
			hex_cnt_d   = 2'd0;
			accum_d     = 16'd0;
			high_pend_d = 1'b0;
			high_bits_d = 10'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_TEXT;
			hex_cnt_q   <= 2'd0;
			accum_q     <= 16'd0;
			high_pend_q <= 1'b0;
			high_bits_q <= 10'd0;
		end else if (take) begin
			mode_q      <= mode_d;
			hex_cnt_q   <= hex_cnt_d;
			accum_q     <= accum_d;
			high_pend_q <= high_pend_d;
			high_bits_q <= high_bits_d;
		end
	end

	assign push      = take && gen;
	assign push_data = ent;

	assert property (@(posedge clk) disable iff (!arst_n)
		high_pend_q |-> (mode_q == MODE_WANT_BSL || mode_q == MODE_WANT_U ||
			mode_q == MODE_HEX))
		else $error("surrogate pending outside the low-half sequence");

	assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q != MODE_HEX) |-> (hex_cnt_q == 2'd0))
		else $error("hex digit count left nonzero outside hex mode");

endmodule

[rtl/jsud_queue.sv]
`timescale 1ns / 1ps
module jsud_queue
	import jsud_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  burst_t push_data,
	output logic   full,
	input  logic   pop,
	output logic   head_valid,
	output burst_t head
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	burst_t          mem_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]   cnt_q;

	assign full       = (cnt_q == CW'(DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) !(push && full))
		else $error("request written into a full queue");

	assert property (@(posedge clk) disable iff (!arst_n) !(pop && !head_valid))
		else $error("request taken from an empty queue");

endmodule

[rtl/jsud_back.sv]
`timescale 1ns / 1ps
module jsud_back
	import jsud_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         head_valid,
	input  burst_t       head,
	output logic         pop,
	output logic         res_valid,
	input  logic         res_stall,
	output logic [1:0]   kind,
	output logic [7:0]   data_byte,
	output logic [2:0]   error_code,
	output logic         last
);

	logic [1:0] idx_q;
	logic       load;
	logic       is_last;

	logic       vld_q;
	logic [1:0] kind_q;
	logic [7:0] data_q;
	logic [2:0] err_q;
	logic       last_q;

	assign load    = head_valid && (!vld_q || !res_stall);
	assign is_last = (idx_q == head.last_idx);
	assign pop     = load && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
			idx_q <= 2'd0;
		end else begin
			if (load) begin
				vld_q <= 1'b1;
				idx_q <= is_last ? 2'd0 : idx_q + 2'd1;
			end else if (!res_stall) begin
				vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q <= head.kind;
			data_q <= head.bytes[idx_q];
			err_q  <= head.err;
			last_q <= is_last;
		end
	end

	assign res_valid  = vld_q;
	assign kind       = kind_q;
	assign data_byte  = data_q;
	assign error_code = err_q;
	assign last       = last_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q && kind_q != KIND_DATA) |-> last_q)
		else $error("end or error result not marked last");

	assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q && kind_q != KIND_ERROR) |-> (err_q == ERR_NONE))
		else $error("error code on a non-error result");

endmodule
